FILE: design/first_fit_heap_allocator_assert.svh
// Assertion macros for the first-fit heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define FFHA_ASSERT_IMP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FFHA_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define FFHA_ASSERT_IMP(lbl, clk, rst_n, prop, msg)
`define FFHA_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

FILE: design/ffha_pkg.sv
// Shared types, constants and helpers of the first-fit heap allocator.
package ffha_pkg;

	localparam int HEAP_BYTES_DEF = 4096;
	localparam int OW = 17;
	localparam logic [10:0] MIN_BLOCK_RESET = 11'd18;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_ZERO = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	typedef struct packed {
		logic cmd;
		logic [14:0] request_size;
		logic [14:0] block_address;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [14:0] data_address;
	} rsp_t;

	typedef struct packed {
		logic [OW-1:0] a;
		logic [OW-1:0] b;
		logic [1:0] c;
	} alu_op_t;

	typedef struct packed {
		logic [OW-1:0] sum;
		logic carry;
	} alu_res_t;

	function automatic logic [OW-1:0] zext15(input logic [14:0] v);
		return {{(OW-15){1'b0}}, v};
	endfunction

endpackage

FILE: design/ffha_ram.sv
// Generic single-port RAM with registered read data.
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = ffha_pkg::HEAP_BYTES_DEF
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/ffha_alu.sv
// Shared adder and comparator: a + b + c, carry out gives a >= b on subtract.
module ffha_alu (
	input ffha_pkg::alu_op_t op,
	output ffha_pkg::alu_res_t res
);

	logic [ffha_pkg::OW:0] total;

	assign total = {1'b0, op.a} + {1'b0, op.b} + {{(ffha_pkg::OW-1){1'b0}}, op.c};
	assign res.sum = total[ffha_pkg::OW-1:0];
	assign res.carry = total[ffha_pkg::OW];

endmodule

FILE: design/ffha_ctrl.sv
// Sequencer that walks block headers and drives the shared adder and heap RAM.
module ffha_ctrl #(
	parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input ffha_pkg::req_t request,
	output logic done,
	output ffha_pkg::rsp_t result,
	input logic cfg_we,
	input logic [10:0] cfg_wdata,
	output ffha_pkg::alu_op_t alu_op,
	input ffha_pkg::alu_res_t alu_res,
	output logic ram_we,
	output logic [$clog2(HEAP_BYTES)-1:0] ram_addr,
	output logic [7:0] ram_wdata,
	input logic [7:0] ram_rdata
);

	localparam int AW = $clog2(HEAP_BYTES);
	localparam int OW = ffha_pkg::OW;
	localparam logic [OW-1:0] HEAP_W = OW'(HEAP_BYTES);
	localparam logic [AW-1:0] CLR_LAST = AW'(HEAP_BYTES - 1);
	localparam logic [14:0] INIT_SIZE = 15'(HEAP_BYTES - 2);

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_FIN,
		ST_FETCH_LO, ST_FETCH_HI, ST_FETCH_GOT,
		ST_A_CHK, ST_A_NEXT, ST_A_REM, ST_A_THR,
		ST_S_W0, ST_S_W1, ST_S_W2, ST_S_W3, ST_N_W, ST_A_DONE,
		ST_F_RD, ST_F_WR,
		ST_M_CHK, ST_M_NXT, ST_M_CHK2, ST_M_FIT, ST_M_WHI, ST_M_ADV
	} state_t;

	state_t state_q, ret_q;
	logic [AW-1:0] clr_q;
	logic [10:0] min_q;
	logic done_q;
	ffha_pkg::rsp_t result_q;
	logic [14:0] size_q, addr_q, hsz_q, sz_q, rem_q, rem2_q;
	logic [OW-1:0] off_q, hdr_q, merged_q;
	logic [7:0] lo_q, hhi_q;
	logic hfree_q, oob_q;

	logic [OW-1:0] mem_a;
	logic mem_wr, mem_in;
	logic [7:0] mem_wd, rd_byte;
	logic [10:0] thresh;
	logic merge_fit;

	assign mem_in = mem_a < HEAP_W;
	assign rd_byte = oob_q ? 8'h00 : ram_rdata;
	assign thresh = (min_q < 11'd2) ? 11'd2 : min_q;
	assign merge_fit = !alu_res.carry && (alu_res.sum <= HEAP_W);

	always_comb begin
		alu_op = '0;
		mem_a = off_q;
		mem_wr = 1'b0;
		mem_wd = 8'h00;
		unique case (state_q)
			ST_CLEAR: begin
				mem_a = {{(OW-AW){1'b0}}, clr_q};
				mem_wr = 1'b1;
				if (clr_q == '0) begin
					mem_wd = INIT_SIZE[7:0];
				end else if (clr_q == AW'(1)) begin
					mem_wd = {1'b1, INIT_SIZE[14:8]};
				end
			end
			ST_IDLE, ST_FIN: begin
			end
			ST_FETCH_LO: begin
				mem_a = hdr_q;
			end
			ST_FETCH_HI: begin
				alu_op = '{a: hdr_q, b: '0, c: 2'd1};
				mem_a = alu_res.sum;
			end
			ST_FETCH_GOT, ST_M_CHK: begin
			end
			ST_A_CHK, ST_A_REM: begin
				alu_op = '{a: ffha_pkg::zext15(hsz_q), b: ~ffha_pkg::zext15(size_q), c: 2'd1};
			end
			ST_A_NEXT: begin
				alu_op = '{a: off_q, b: ffha_pkg::zext15(hsz_q), c: 2'd2};
			end
			ST_A_THR: begin
				alu_op = '{a: ffha_pkg::zext15(rem_q), b: ~{{(OW-11){1'b0}}, thresh},
					c: 2'd1};
			end
			ST_S_W0: begin
				alu_op = '{a: ffha_pkg::zext15(rem_q), b: ~OW'(2), c: 2'd1};
				mem_wr = 1'b1;
				mem_wd = size_q[7:0];
			end
			ST_S_W1: begin
				alu_op = '{a: off_q, b: '0, c: 2'd1};
				mem_a = alu_res.sum;
				mem_wr = 1'b1;
				mem_wd = {1'b0, size_q[14:8]};
			end
			ST_S_W2: begin
				alu_op = '{a: off_q, b: ffha_pkg::zext15(size_q), c: 2'd2};
				mem_a = alu_res.sum;
				mem_wr = 1'b1;
				mem_wd = rem2_q[7:0];
			end
			ST_S_W3: begin
				alu_op = '{a: off_q, b: ffha_pkg::zext15(size_q), c: 2'd3};
				mem_a = alu_res.sum;
				mem_wr = 1'b1;
				mem_wd = {1'b1, rem2_q[14:8]};
			end
			ST_N_W: begin
				alu_op = '{a: off_q, b: '0, c: 2'd1};
				mem_a = alu_res.sum;
				mem_wr = 1'b1;
				mem_wd = {1'b0, hhi_q[6:0]};
			end
			ST_A_DONE: begin
				alu_op = '{a: off_q, b: '0, c: 2'd2};
			end
			ST_F_RD: begin
				alu_op = '{a: ffha_pkg::zext15(addr_q), b: ~OW'(1), c: 2'd1};
				mem_a = alu_res.sum;
			end
			ST_F_WR: begin
				alu_op = '{a: ffha_pkg::zext15(addr_q), b: ~OW'(1), c: 2'd1};
				mem_a = alu_res.sum;
				mem_wr = 1'b1;
				mem_wd = ram_rdata | 8'h80;
			end
			ST_M_NXT, ST_M_ADV: begin
				alu_op = '{a: off_q, b: ffha_pkg::zext15(sz_q), c: 2'd2};
			end
			ST_M_CHK2: begin
				alu_op = '{a: ffha_pkg::zext15(sz_q), b: ffha_pkg::zext15(hsz_q), c: 2'd2};
			end
			ST_M_FIT: begin
				// The merged block must still end inside the heap.
				alu_op = '{a: off_q, b: merged_q, c: 2'd2};
				mem_wr = merge_fit;
				mem_wd = merged_q[7:0];
			end
			ST_M_WHI: begin
				alu_op = '{a: off_q, b: '0, c: 2'd1};
				mem_a = alu_res.sum;
				mem_wr = 1'b1;
				mem_wd = {1'b1, merged_q[14:8]};
			end
		endcase
	end

	assign ram_we = mem_wr && mem_in;
	assign ram_addr = mem_a[AW-1:0];
	assign ram_wdata = mem_wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ret_q <= ST_IDLE;
			clr_q <= '0;
			min_q <= ffha_pkg::MIN_BLOCK_RESET;
			done_q <= 1'b0;
			result_q <= '0;
			size_q <= '0;
			addr_q <= '0;
			hsz_q <= '0;
			sz_q <= '0;
			rem_q <= '0;
			rem2_q <= '0;
			off_q <= '0;
			hdr_q <= '0;
			merged_q <= '0;
			lo_q <= '0;
			hhi_q <= '0;
			hfree_q <= 1'b0;
			oob_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FIN);
			if (cfg_we) begin
				min_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						if (request.cmd == ffha_pkg::CMD_FREE) begin
							result_q <= '{status: ffha_pkg::STATUS_OK, data_address: '0};
							addr_q <= request.block_address;
							state_q <= (request.block_address == '0) ? ST_FIN : ST_F_RD;
						end else if (request.request_size == '0) begin
							result_q <= '{status: ffha_pkg::STATUS_ZERO, data_address: '0};
							state_q <= ST_FIN;
						end else begin
							result_q <= '{status: ffha_pkg::STATUS_OK, data_address: '0};
							size_q <= (request.request_size < {4'b0, min_q}) ?
								{4'b0, min_q} : request.request_size;
							off_q <= '0;
							hdr_q <= '0;
							ret_q <= ST_A_CHK;
							state_q <= ST_FETCH_LO;
						end
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				ST_FETCH_LO: begin
					state_q <= ST_FETCH_HI;
				end
				ST_FETCH_HI: begin
					lo_q <= ram_rdata;
					oob_q <= !mem_in;
					state_q <= ST_FETCH_GOT;
				end
				ST_FETCH_GOT: begin
					hsz_q <= {rd_byte[6:0], lo_q};
					hfree_q <= rd_byte[7];
					hhi_q <= rd_byte;
					state_q <= ret_q;
				end
				ST_A_CHK: begin
					state_q <= (hfree_q && alu_res.carry) ? ST_A_REM : ST_A_NEXT;
				end
				ST_A_NEXT: begin
					if (alu_res.sum >= HEAP_W) begin
						result_q.status <= ffha_pkg::STATUS_FULL;
						state_q <= ST_FIN;
					end else begin
						off_q <= alu_res.sum;
						hdr_q <= alu_res.sum;
						state_q <= ST_FETCH_LO;
					end
				end
				ST_A_REM: begin
					rem_q <= alu_res.sum[14:0];
					state_q <= ST_A_THR;
				end
				ST_A_THR: begin
					state_q <= alu_res.carry ? ST_S_W0 : ST_N_W;
				end
				ST_S_W0: begin
					rem2_q <= alu_res.sum[14:0];
					state_q <= ST_S_W1;
				end
				ST_S_W1: begin
					state_q <= ST_S_W2;
				end
				ST_S_W2: begin
					state_q <= ST_S_W3;
				end
				ST_S_W3, ST_N_W: begin
					state_q <= ST_A_DONE;
				end
				ST_A_DONE: begin
					result_q.data_address <= alu_res.sum[14:0];
					state_q <= ST_FIN;
				end
				ST_F_RD: begin
					oob_q <= !mem_in;
					state_q <= ST_F_WR;
				end
				ST_F_WR: begin
					off_q <= '0;
					hdr_q <= '0;
					ret_q <= ST_M_CHK;
					state_q <= ST_FETCH_LO;
				end
				ST_M_CHK: begin
					sz_q <= hsz_q;
					state_q <= hfree_q ? ST_M_NXT : ST_M_ADV;
				end
				ST_M_NXT: begin
					if (alu_res.sum >= HEAP_W) begin
						state_q <= ST_FIN;
					end else begin
						hdr_q <= alu_res.sum;
						ret_q <= ST_M_CHK2;
						state_q <= ST_FETCH_LO;
					end
				end
				ST_M_CHK2: begin
					merged_q <= alu_res.sum;
					state_q <= hfree_q ? ST_M_FIT : ST_M_ADV;
				end
				ST_M_FIT: begin
					state_q <= merge_fit ? ST_M_WHI : ST_M_ADV;
				end
				ST_M_WHI: begin
					// The merged header stays free; look at its new neighbor next.
					sz_q <= merged_q[14:0];
					state_q <= ST_M_NXT;
				end
				ST_M_ADV: begin
					if (alu_res.sum >= HEAP_W) begin
						state_q <= ST_FIN;
					end else begin
						off_q <= alu_res.sum;
						hdr_q <= alu_res.sum;
						ret_q <= ST_M_CHK;
						state_q <= ST_FETCH_LO;
					end
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign result = result_q;

endmodule

FILE: design/first_fit_heap_allocator.sv
// Timing: a refused or empty request goes straight to the finish state and then to done; a walk
// visits each block header with two byte reads of the single-port heap RAM (through the
// shared adder), and then splits or marks the found block.
// Throughput: one request at a time; busy stays high until the done beat.
// Reset: after arst_n rises the heap RAM is cleared, HEAP_BYTES cycles, busy high meanwhile.
// Results are a one-cycle done strobe; the receiver cannot stall.
`include "first_fit_heap_allocator_assert.svh"

module first_fit_heap_allocator #(
	parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input ffha_pkg::req_t request,
	output logic done,
	output ffha_pkg::rsp_t result,
	input logic cfg_we,
	input logic [10:0] cfg_wdata
);

	localparam int AW = $clog2(HEAP_BYTES);

	ffha_pkg::alu_op_t alu_op;
	ffha_pkg::alu_res_t alu_res;
	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [7:0] ram_wdata, ram_rdata;

	ffha_ctrl #(
		.HEAP_BYTES(HEAP_BYTES)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.alu_op(alu_op),
		.alu_res(alu_res),
		.ram_we(ram_we),
		.ram_addr(ram_addr),
		.ram_wdata(ram_wdata),
		.ram_rdata(ram_rdata)
	);

	ffha_alu u_alu (
		.op(alu_op),
		.res(alu_res)
	);

	ffha_ram #(
		.WIDTH(8),
		.DEPTH(HEAP_BYTES)
	) u_heap (
		.clk(clk),
		.we(ram_we),
		.addr(ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	`FFHA_ASSERT_IMP(a_done_when_idle, clk, arst_n, done |-> !busy, "done beat while busy")
	`FFHA_ASSERT_IMP(a_accept_goes_busy, clk, arst_n, (start && !busy) |=> busy, "accepted beat did not start work")
	`FFHA_ASSERT_IMP(a_done_one_cycle, clk, arst_n, done |=> !done, "done held for more than one cycle")
	`FFHA_ASSERT_NEVER(a_no_idle_write, clk, arst_n, ram_we && !busy, "heap written while idle")

endmodule

FILE: tb/first_fit_heap_allocator_tb.sv
// Self-checking testbench for the first-fit heap allocator: random commands against a byte-level heap predictor.
module first_fit_heap_allocator_tb;
	import ffha_pkg::*;

	localparam int HEAP = HEAP_BYTES_DEF;
	localparam int QUIET_LIMIT = 100000;
	localparam int PHASE_ITEMS = 140;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t request = '0;
	logic done;
	rsp_t result;
	logic cfg_we = 1'b0;
	logic [10:0] cfg_wdata = '0;

	// Predicted heap contents and the minimum block setting the block should be using.
	logic [7:0] heap_image [HEAP];
	logic [10:0] min_block;

	req_t request_backlog [$];
	rsp_t expected_responses [$];
	logic [14:0] granted_offsets [$];

	int mismatch_count = 0;
	int quiet_cycles = 0;
	int idle_left = 0;
	int burst_left = 0;

	first_fit_heap_allocator #(
		.HEAP_BYTES(HEAP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] heap_peek(int unsigned a);
		return (a < HEAP) ? heap_image[a] : 8'h00;
	endfunction

	function automatic void heap_poke(int unsigned a, logic [7:0] v);
		if (a < HEAP)
			heap_image[a] = v;
	endfunction

	function automatic logic [14:0] tag_size(int unsigned a);
		logic [15:0] w;
		w = {heap_peek(a + 1), heap_peek(a)};
		return w[14:0];
	endfunction

	function automatic logic tag_free(int unsigned a);
		logic [7:0] b;
		b = heap_peek(a + 1);
		return b[7];
	endfunction

	function automatic void tag_mark(int unsigned a, logic is_free);
		logic [7:0] b;
		b = heap_peek(a + 1);
		b[7] = is_free;
		heap_poke(a + 1, b);
	endfunction

	function automatic void tag_resize(int unsigned a, int unsigned s);
		logic [14:0] s15;
		logic [7:0] b;
		s15 = 15'(s);
		heap_poke(a, s15[7:0]);
		b = heap_peek(a + 1);
		heap_poke(a + 1, {b[7], s15[14:8]});
	endfunction

	// Walks the whole chain and folds each free block into its free predecessor. A merge that
	// would run past the end of the heap is skipped, which keeps a damaged chain finite.
	function automatic void coalesce_free_runs();
		int unsigned off;
		int unsigned sz;
		int unsigned nxt;
		int unsigned merged;
		off = 0;
		while (1'b1) begin
			sz = tag_size(off);
			if (tag_free(off)) begin
				nxt = off + sz + 2;
				if (nxt >= HEAP)
					break;
				if (tag_free(nxt)) begin
					merged = sz + tag_size(nxt) + 2;
					if (off + 2 + merged <= HEAP) begin
						tag_resize(off, merged);
						continue;
					end
				end
			end
			off = off + sz + 2;
			if (off >= HEAP)
				break;
		end
	endfunction

	function automatic rsp_t allocator_response(req_t r);
		rsp_t rsp;
		int unsigned want;
		int unsigned off;
		int unsigned blk;
		int unsigned rem;
		int unsigned thresh;
		int unsigned nxt;
		bit found;
		rsp.status = STATUS_OK;
		rsp.data_address = '0;
		if (r.cmd == CMD_FREE) begin
			// Any nonzero address sets the flag bit of the byte before it, header or not.
			if (r.block_address != 0) begin
				heap_poke(r.block_address - 1, heap_peek(r.block_address - 1) | 8'h80);
				coalesce_free_runs();
			end
			return rsp;
		end
		if (r.request_size == 0) begin
			rsp.status = STATUS_ZERO;
			return rsp;
		end
		want = r.request_size;
		if (want < min_block)
			want = min_block;
		off = 0;
		found = 1'b0;
		while (!found && off < HEAP) begin
			blk = tag_size(off);
			if (tag_free(off) && blk >= want)
				found = 1'b1;
			else
				off = off + blk + 2;
		end
		if (!found) begin
			rsp.status = STATUS_FULL;
			return rsp;
		end
		rem = blk - want;
		thresh = (min_block < 2) ? 2 : min_block;
		if (rem >= thresh) begin
			nxt = off + want + 2;
			tag_resize(off, want);
			tag_mark(nxt, 1'b1);
			tag_resize(nxt, rem - 2);
		end
		tag_mark(off, 1'b0);
		rsp.data_address = 15'(off + 2);
		return rsp;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t: mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	function automatic req_t compose_request(logic c, logic [14:0] size, logic [14:0] addr);
		req_t r;
		r.cmd = c;
		r.request_size = size;
		r.block_address = addr;
		return r;
	endfunction

	// Mostly allocations and frees of live blocks; a few refused, oversized, stray and double
	// frees. Stray frees land inside the heap only when corrupting is set.
	function automatic req_t next_request(bit corrupting);
		req_t r;
		int roll;
		int pick;
		int idx;
		roll = $urandom_range(0, 99);
		r.cmd = CMD_ALLOC;
		r.request_size = 15'($urandom_range(0, 32767));
		r.block_address = 15'($urandom_range(0, 32767));
		if (roll < 3) begin
			r.request_size = '0;
		end else if (roll < 6) begin
			r.request_size = 15'($urandom_range(HEAP, 32767));
		end else if (roll < 9) begin
			r.cmd = CMD_FREE;
			if (corrupting)
				r.block_address = 15'($urandom_range(1, HEAP));
			else if ($urandom_range(0, 1) == 0)
				r.block_address = '0;
			else
				r.block_address = 15'($urandom_range(HEAP + 1, 32767));
		end else if (roll < 11 && granted_offsets.size() > 0) begin
			// Free a live block but keep it listed, so it can be freed again later.
			r.cmd = CMD_FREE;
			r.block_address = granted_offsets[$urandom_range(0, granted_offsets.size() - 1)];
		end else if (granted_offsets.size() > 0 && (granted_offsets.size() > 28 || roll < 50)) begin
			idx = $urandom_range(0, granted_offsets.size() - 1);
			r.cmd = CMD_FREE;
			r.block_address = granted_offsets[idx];
			granted_offsets.delete(idx);
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 65)
				r.request_size = 15'($urandom_range(1, 48));
			else if (pick < 92)
				r.request_size = 15'($urandom_range(49, 400));
			else
				r.request_size = 15'($urandom_range(401, HEAP - 2));
		end
		return r;
	endfunction

	task automatic queue_request(req_t r);
		while (request_backlog.size() >= 2)
			@(negedge clk);
		request_backlog.push_back(r);
	endtask

	// Waits until the allocator is idle with no command pending and no result outstanding.
	task automatic settle_heap();
		do
			@(negedge clk);
		while (request_backlog.size() != 0 || start || busy || expected_responses.size() != 0);
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_requests
		rsp_t predicted;
		int roll;
		if (!arst_n) begin
			start <= 1'b0;
			idle_left = 0;
			burst_left = 0;
		end else begin
			if (start && !busy) begin
				predicted = allocator_response(request);
				expected_responses.push_back(predicted);
				if (request.cmd == CMD_ALLOC && predicted.status == STATUS_OK)
					granted_offsets.push_back(predicted.data_address);
				if (burst_left > 0) begin
					burst_left--;
					idle_left = 0;
				end else begin
					roll = $urandom_range(0, 99);
					if (roll < 4) begin
						burst_left = $urandom_range(20, 60);
						idle_left = 0;
					end else if (roll < 55) begin
						idle_left = 0;
					end else if (roll < 85) begin
						idle_left = $urandom_range(1, 3);
					end else if (roll < 97) begin
						idle_left = $urandom_range(4, 12);
					end else begin
						idle_left = $urandom_range(20, 80);
					end
				end
			end
			// A command that is still waiting for busy to drop stays on the port unchanged.
			if (!(start && busy)) begin
				if (idle_left > 0) begin
					idle_left--;
					start <= 1'b0;
				end else if (request_backlog.size() > 0) begin
					request <= request_backlog.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_responses
		rsp_t oldest;
		if (arst_n && done) begin
			if (expected_responses.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing expected: status %0d address %0d",
					result.status, result.data_address));
			end else begin
				oldest = expected_responses.pop_front();
				if (result.status !== oldest.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						result.status, oldest.status));
				if (result.data_address !== oldest.data_address)
					report_mismatch($sformatf("data_address %0d, expected %0d",
						result.data_address, oldest.data_address));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("%0t: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
					$display("TEST FAILED");
					$finish;
				end
			end
		end
	end

	initial begin
		logic [14:0] live [$];
		logic [10:0] setting;
		for (int i = 0; i < HEAP; i++)
			heap_image[i] = 8'h00;
		tag_mark(0, 1'b1);
		tag_resize(0, HEAP - 2);
		min_block = MIN_BLOCK_RESET;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Refusals, a size below the minimum, a grant too short to split and a full heap.
		queue_request(compose_request(CMD_FREE, 15'd0, 15'd0));
		queue_request(compose_request(CMD_ALLOC, 15'd0, 15'd0));
		queue_request(compose_request(CMD_ALLOC, 15'd32767, 15'd0));
		queue_request(compose_request(CMD_ALLOC, 15'd1, 15'd0));
		queue_request(compose_request(CMD_ALLOC, 15'd17, 15'd0));
		queue_request(compose_request(CMD_ALLOC, 15'd19, 15'd0));
		queue_request(compose_request(CMD_ALLOC, 15'd4020, 15'd0));
		queue_request(compose_request(CMD_ALLOC, 15'd1, 15'd0));
		settle_heap();
		live = granted_offsets;
		granted_offsets.delete();
		// Free out of order so that merges happen both forward and across several blocks.
		queue_request(compose_request(CMD_FREE, 15'd0, live[1]));
		queue_request(compose_request(CMD_FREE, 15'd0, live[0]));
		queue_request(compose_request(CMD_FREE, 15'd0, live[3]));
		queue_request(compose_request(CMD_FREE, 15'd0, live[2]));
		queue_request(compose_request(CMD_FREE, 15'd0, 15'd32767));
		queue_request(compose_request(CMD_FREE, 15'd0, 15'(HEAP + 1)));
		// Leftover exactly at the split threshold, then nothing left that fits.
		queue_request(compose_request(CMD_ALLOC, 15'(HEAP - 20), 15'd0));
		queue_request(compose_request(CMD_ALLOC, 15'd16, 15'd0));
		queue_request(compose_request(CMD_ALLOC, 15'(HEAP - 2), 15'd0));
		settle_heap();
		queue_request(compose_request(CMD_FREE, 15'd0, granted_offsets[0]));
		granted_offsets.delete();
		queue_request(compose_request(CMD_ALLOC, 15'(HEAP - 2), 15'd0));
		settle_heap();
		queue_request(compose_request(CMD_FREE, 15'd0, granted_offsets[0]));
		granted_offsets.delete();

		for (int p = 0; p < 6; p++) begin
			if (p > 0) begin
				case (p)
					1: setting = 11'd3;
					2: setting = 11'd1024;
					3: setting = 11'($urandom_range(3, 1024));
					4: setting = 11'd1023;
					default: setting = 11'($urandom_range(3, 40));
				endcase
				settle_heap();
				@(posedge clk);
				cfg_we <= 1'b1;
				cfg_wdata <= setting;
				@(posedge clk);
				cfg_we <= 1'b0;
				min_block = setting;
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2) begin
					settle_heap();
					repeat ($urandom_range(0, 200)) @(posedge clk);
				end
				// The last phase also sets flag bits at arbitrary heap bytes.
				queue_request(next_request(p == 5));
			end
		end

		settle_heap();
		repeat (64) @(posedge clk);
		if (expected_responses.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_responses.size()));
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
